// ===== src/ble_eid_pkg.sv =====
package ble_eid_pkg;

  localparam int ID_BYTES = 20;
  localparam int IDX_W = $clog2(ID_BYTES);

  localparam logic [7:0] AD_SERVICE_DATA16 = 8'h16;
  localparam logic [7:0] MIN_STRUCT_LEN = 8'(4 + ID_BYTES);
  localparam logic [7:0] ID_FIRST_POS = 8'd4;
  localparam logic [7:0] POS_TYPE = 8'd0;
  localparam logic [7:0] POS_UUID_LO = 8'd1;
  localparam logic [7:0] POS_UUID_HI = 8'd2;
  localparam logic [7:0] POS_KIND = 8'd3;
  localparam logic [7:0] KIND_A = 8'h40;
  localparam logic [7:0] KIND_B = 8'h41;
  localparam logic [15:0] UUID_RESET = {8'hFE, 8'hAA};

  localparam int REG_SERVICE_UUID = 0;
  localparam int PADDR_W = 3;

  typedef logic [ID_BYTES-1:0][7:0] id_array_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [7:0]       eid_byte;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       frame_kind;
    logic             run_end;
  } out_beat_t;

  // handoff from parser to emitter on the final byte of an advertisement
  typedef struct packed {
    logic       launch;
    logic       found;
    logic [7:0] frame_kind;
    id_array_t  ids;
  } run_t;

endpackage

// ===== src/ble_eid_parser.sv =====
module ble_eid_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  ble_eid_pkg::in_beat_t beat_i,
  input  logic [15:0]          service_uuid_i,
  output ble_eid_pkg::run_t    run_o
);
  import ble_eid_pkg::*;

  logic [7:0] left_q, left_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic       cand_q, cand_d;
  logic       stop_q, stop_d;
  logic       done_q, done_d;
  logic [7:0] kind_q, kind_d;
  id_array_t  id_q, id_next;
  logic       id_we;
  logic [IDX_W-1:0] id_idx;
  logic [7:0] b;

  assign b = beat_i.payload_byte;
  assign id_idx = IDX_W'(pos_q - ID_FIRST_POS);

  always_comb begin
    left_d = left_q;
    pos_d  = pos_q;
    len_d  = len_q;
    type_d = type_q;
    cand_d = cand_q;
    stop_d = stop_q;
    done_d = done_q;
    kind_d = kind_q;
    id_we  = 1'b0;
    if (take_i && !stop_q && !done_q) begin
      if (left_q == 8'd0) begin
        if (b == 8'd0) begin
          stop_d = 1'b1;
        end else begin
          len_d  = b;
          left_d = b;
          pos_d  = 8'd0;
          cand_d = 1'b1;
        end
      end else begin
        case (pos_q)
          POS_TYPE: begin
            type_d = b;
            if (b != AD_SERVICE_DATA16 || len_q < MIN_STRUCT_LEN) cand_d = 1'b0;
          end
          POS_UUID_LO: begin
            if (b != service_uuid_i[7:0]) cand_d = 1'b0;
          end
          POS_UUID_HI: begin
            if (b != service_uuid_i[15:8]) cand_d = 1'b0;
          end
          POS_KIND: begin
            if (b == KIND_A || b == KIND_B) begin
              if (cand_q) kind_d = b;
            end else begin
              cand_d = 1'b0;
            end
          end
          default: begin
            if (pos_q < MIN_STRUCT_LEN && cand_q) id_we = 1'b1;
          end
        endcase
        pos_d  = pos_q + 8'd1;
        left_d = left_q - 8'd1;
        if (left_d == 8'd0 && cand_d) done_d = 1'b1;
      end
    end
  end

  // buffer contents including a byte written on this same beat
  always_comb begin
    id_next = id_q;
    if (id_we) id_next[id_idx] = b;
  end

  assign run_o.launch     = take_i && beat_i.last_byte;
  assign run_o.found      = done_d;
  assign run_o.frame_kind = kind_d;
  assign run_o.ids        = id_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      pos_q  <= '0;
      len_q  <= '0;
      type_q <= '0;
      cand_q <= 1'b0;
      stop_q <= 1'b0;
      done_q <= 1'b0;
      kind_q <= '0;
    end else if (run_o.launch) begin
      left_q <= '0;
      pos_q  <= '0;
      len_q  <= '0;
      type_q <= '0;
      cand_q <= 1'b0;
      stop_q <= 1'b0;
      done_q <= 1'b0;
      kind_q <= '0;
    end else begin
      left_q <= left_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      type_q <= type_d;
      cand_q <= cand_d;
      stop_q <= stop_d;
      done_q <= done_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we) id_q[id_idx] <= b;
  end

endmodule

// ===== src/ble_service_data_eid_extractor.sv =====
// Input: one payload byte per cycle unless stalled, each parsed in the cycle accepted.
// Output: the final byte starts the emitter, which fills the output register; a run is
// 1 beat (not found) or 20 beats (identifier), one beat per cycle unless stalled.
// A final byte is held off while the previous run still drains from the emitter.
// Reset (rst_ni low, async): parse state and handshakes clear, service_uuid -> 0xFEAA.
module ble_service_data_eid_extractor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ble_eid_pkg::in_beat_t         in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ble_eid_pkg::out_beat_t        out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ble_eid_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ble_eid_pkg::*;

  logic [15:0] uuid_q;
  logic        cfg_we;
  logic        take;
  run_t        run;

  logic             busy_q;
  logic [IDX_W-1:0] cnt_q;
  logic             efound_q;
  logic [7:0]       ekind_q;
  id_array_t        eids_q;
  logic             out_load;
  logic             run_last;
  logic             run_done;

  logic      out_valid_q;
  out_beat_t out_data_q;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == 1'(REG_SERVICE_UUID));
  assign prdata = (paddr[PADDR_W-1:2] == 1'(REG_SERVICE_UUID)) ? {16'd0, uuid_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uuid_q <= UUID_RESET;
    end else if (cfg_we) begin
      uuid_q <= pwdata[15:0];
    end
  end

  // a final byte needs the emitter free, or freeing on this edge
  assign in_stall_o = busy_q && !run_done && in_data_i.last_byte;
  assign take = in_valid_i && !in_stall_o;

  ble_eid_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .beat_i        (in_data_i),
    .service_uuid_i(uuid_q),
    .run_o         (run)
  );

  // emitter
  assign out_load = busy_q && (!out_valid_q || !out_stall_i);
  assign run_last = !efound_q || (cnt_q == IDX_W'(ID_BYTES - 1));
  assign run_done = out_load && run_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run.launch) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (out_load) begin
      if (run_last) busy_q <= 1'b0;
      cnt_q <= cnt_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (run.launch) begin
      efound_q <= run.found;
      ekind_q  <= run.frame_kind;
      eids_q   <= run.ids;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (efound_q) begin
        out_data_q.found      <= 1'b1;
        out_data_q.eid_byte   <= eids_q[cnt_q];
        out_data_q.byte_index <= cnt_q;
        out_data_q.frame_kind <= ekind_q;
        out_data_q.run_end    <= run_last;
      end else begin
        out_data_q.found      <= 1'b0;
        out_data_q.eid_byte   <= '0;
        out_data_q.byte_index <= '0;
        out_data_q.frame_kind <= '0;
        out_data_q.run_end    <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/ble_eid_checker.sv =====
module ble_eid_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input ble_eid_pkg::out_beat_t        out_data_o
);
  import ble_eid_pkg::*;

  logic out_beat;
  assign out_beat = out_valid_o && !out_stall_i;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // not-found result is a single zeroed beat
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.run_end && out_data_o.eid_byte == 8'd0 &&
      out_data_o.byte_index == '0 && out_data_o.frame_kind == 8'd0)
    else $error("malformed not-found beat");

  // identifier run is gap-free and counts up
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_data_o.found && !out_data_o.run_end |=>
      out_valid_o && out_data_o.found &&
      out_data_o.byte_index == $past(out_data_o.byte_index) + IDX_W'(1))
    else $error("identifier run broken");

  // found runs carry a valid frame kind and end at the last index
  a_found_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |->
      (out_data_o.frame_kind == KIND_A || out_data_o.frame_kind == KIND_B) &&
      (out_data_o.run_end == (out_data_o.byte_index == IDX_W'(ID_BYTES - 1))))
    else $error("bad found beat");

endmodule

bind ble_service_data_eid_extractor ble_eid_checker u_ble_eid_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ble_eid_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;

  // Tracks the parse of the advertisement in flight and holds the result
  // beats that the block still owes.
  class eid_run_tracker;
    logic [15:0] uuid_cfg;
    logic [7:0]  remaining;
    logic [7:0]  offset;
    logic [7:0]  ad_len;
    logic [7:0]  kind_seen;
    bit          still_good;
    bit          walk_over;
    bit          have_match;
    logic [7:0]  eid_bytes[ID_BYTES];
    out_beat_t   due_beats[$];
    int          bad_count;

    function new();
      uuid_cfg = UUID_RESET;
      foreach (eid_bytes[k]) eid_bytes[k] = 8'h00;
      bad_count = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      remaining = 8'd0;
      offset = 8'd0;
      ad_len = 8'd0;
      kind_seen = 8'd0;
      still_good = 1'b0;
      walk_over = 1'b0;
      have_match = 1'b0;
    endfunction

    function void flag(string msg);
      bad_count++;
      if (bad_count <= 10) $display("%s", msg);
    endfunction

    function void accept_byte(in_beat_t beat);
      logic [7:0] b;
      out_beat_t  r;
      b = beat.payload_byte;
      if (!walk_over && !have_match) begin
        if (remaining == 8'd0) begin
          if (b == 8'd0) begin
            walk_over = 1'b1;
          end else begin
            ad_len = b;
            remaining = b;
            offset = 8'd0;
            still_good = 1'b1;
          end
        end else begin
          if (offset == POS_TYPE) begin
            if (b != AD_SERVICE_DATA16 || ad_len < MIN_STRUCT_LEN) still_good = 1'b0;
          end else if (offset == POS_UUID_LO) begin
            if (b != uuid_cfg[7:0]) still_good = 1'b0;
          end else if (offset == POS_UUID_HI) begin
            if (b != uuid_cfg[15:8]) still_good = 1'b0;
          end else if (offset == POS_KIND) begin
            if (b == KIND_A || b == KIND_B) begin
              if (still_good) kind_seen = b;
            end else begin
              still_good = 1'b0;
            end
          end else if (offset < MIN_STRUCT_LEN) begin
            if (still_good) eid_bytes[offset - ID_FIRST_POS] = b;
          end
          offset = offset + 8'd1;
          remaining = remaining - 8'd1;
          // match only counts once the whole structure has arrived
          if (remaining == 8'd0 && still_good) have_match = 1'b1;
        end
      end
      if (beat.last_byte) begin
        if (have_match) begin
          for (int k = 0; k < ID_BYTES; k++) begin
            r.found = 1'b1;
            r.eid_byte = eid_bytes[k];
            r.byte_index = IDX_W'(k);
            r.frame_kind = kind_seen;
            r.run_end = (k == ID_BYTES - 1);
            due_beats.push_back(r);
          end
        end else begin
          r = '0;
          r.run_end = 1'b1;
          due_beats.push_back(r);
        end
        clear_walk();
      end
    endfunction

    function void compare_beat(out_beat_t got);
      out_beat_t want;
      if (due_beats.size() == 0) begin
        flag($sformatf("unexpected beat: found=%0d eid=%02h idx=%0d kind=%02h end=%0d",
                       got.found, got.eid_byte, got.byte_index, got.frame_kind, got.run_end));
      end else begin
        want = due_beats.pop_front();
        if (got.found !== want.found || got.eid_byte !== want.eid_byte ||
            got.byte_index !== want.byte_index || got.frame_kind !== want.frame_kind ||
            got.run_end !== want.run_end)
          flag($sformatf({"mismatch: expected found=%0d eid=%02h idx=%0d kind=%02h end=%0d,",
                          " got found=%0d eid=%02h idx=%0d kind=%02h end=%0d"},
                         want.found, want.eid_byte, want.byte_index, want.frame_kind,
                         want.run_end, got.found, got.eid_byte, got.byte_index,
                         got.frame_kind, got.run_end));
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_beat_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_beat_t            out_data_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  eid_run_tracker tracker = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycles = 0;
  logic [15:0] uuid_now = UUID_RESET;

  ble_service_data_eid_extractor uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.compare_beat(out_data_o);
  end

  // entered and left at a falling edge; valid stays high between beats unless an idle gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_beat_t beat;
    beat.payload_byte = b;
    beat.last_byte = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (in_stall_o);
    tracker.accept_byte(beat);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_advert(input byte_q_t q);
    foreach (q[k]) send_byte(q[k], k == q.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.due_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_uuid(input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_SERVICE_UUID);
    pwdata <= {16'h0000, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    uuid_now = v;
    tracker.uuid_cfg = v;
    @(negedge clk_i);
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== v)
      tracker.flag($sformatf("uuid readback: expected %04h, got %04h", v, prdata[15:0]));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly service-data structures with the odd fault, plus noise and
  // early-terminated walks
  task automatic random_phase(input int n);
    int      start;
    int      len;
    int      fault;
    int      roll;
    byte_q_t q;
    logic [7:0] kind;
    start = items_sent;
    while (items_sent - start < n) begin
      q.delete();
      repeat ($urandom_range(2)) begin
        len = $urandom_range(1, 5);
        q.push_back(8'(len));
        repeat (len) q.push_back(8'($urandom));
      end
      roll = $urandom_range(9);
      if (roll < 6) begin
        repeat (($urandom_range(3) == 0) ? 2 : 1) begin
          fault = $urandom_range(11);
          len = ($urandom_range(2) == 0) ? $urandom_range(25, 40) : int'(MIN_STRUCT_LEN);
          if (fault == 1) len = int'(MIN_STRUCT_LEN) - 1;
          q.push_back(8'(len));
          q.push_back(AD_SERVICE_DATA16 ^ (fault == 0 ? 8'($urandom_range(1, 255)) : 8'h00));
          q.push_back(uuid_now[7:0] ^ (fault == 2 ? 8'($urandom_range(1, 255)) : 8'h00));
          q.push_back(uuid_now[15:8] ^ (fault == 3 ? 8'($urandom_range(1, 255)) : 8'h00));
          if (fault == 4) kind = 8'($urandom);
          else kind = $urandom_range(1) ? KIND_A : KIND_B;
          q.push_back(kind);
          repeat (len - 4) q.push_back(8'($urandom));
          // cut off by the end of the advertisement
          if (fault == 5) repeat ($urandom_range(1, len)) void'(q.pop_back());
        end
        case ($urandom_range(3))
          1: begin
            q.push_back(8'h00);
            repeat ($urandom_range(4)) q.push_back(8'($urandom));
          end
          2: q.push_back(8'($urandom_range(1, 255)));
          default: ;
        endcase
      end else if (roll < 8) begin
        repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
      end else begin
        q.push_back(8'h00);
        repeat ($urandom_range(30)) q.push_back(8'($urandom));
      end
      send_advert(q);
      if ($urandom_range(5) == 0) drain();
    end
  endtask

  initial begin
    byte_q_t q;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero length alone, lone length byte, truncated, stopped walk with junk
    q = {8'h00};
    send_advert(q);
    q = {8'hFF};
    send_advert(q);
    q = {8'h03, 8'h16, 8'hAA};
    send_advert(q);
    q = {8'h00, 8'h16, 8'hFF, 8'h12};
    send_advert(q);
    // minimal structure whose last byte is the final byte
    q = {MIN_STRUCT_LEN, AD_SERVICE_DATA16, UUID_RESET[7:0], UUID_RESET[15:8], KIND_B};
    for (int k = 0; k < ID_BYTES; k++)
      q.push_back((k == 0) ? 8'h00 : (k == ID_BYTES - 1) ? 8'hFF : 8'($urandom));
    send_advert(q);

    random_phase(10);
    drain();

    write_uuid(16'h0000);
    send_idle_pct = 70;
    random_phase(10);
    drain();

    write_uuid(16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 70;
    random_phase(10);
    drain();

    write_uuid(16'($urandom));
    send_idle_pct = 23;
    stall_pct = 23;
    random_phase(10);
    drain();

    if (tracker.bad_count == 0 && tracker.due_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
